// ===== rtl/button_hold_lid_debouncer_core_assert.svh =====
// Assertion macros for the button/lid debouncer core.
// Used by button_hold_lid_debouncer_core; expects i_clk and i_rst_n in scope.
`ifndef BUTTON_HOLD_LID_DEBOUNCER_CORE_ASSERT_SVH
`define BUTTON_HOLD_LID_DEBOUNCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BHLD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");

// Next-cycle implication, checked outside reset
`define BHLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");

`endif

// ===== rtl/bhld_pkg.sv =====
// Shared types and constants for the button/lid debouncer.
// No dependencies; used by all modules in rtl/.
package bhld_pkg;

    // Stable / candidate states of a button
    typedef enum logic [1:0] {
        BTN_RELEASED = 2'd0,
        BTN_PRESSED  = 2'd1,
        BTN_HELD     = 2'd2
    } t_btn_state;

    // Lid states
    localparam logic LID_OPEN = 1'b0;
    localparam logic LID_SHUT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LID_DEBOUNCE = 2'd2;

    localparam int CFG_W  = 16;
    localparam int TIME_W = 32;

    localparam logic [CFG_W-1:0] HOLD_TIME_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] BTN_DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LID_DEBOUNCE_RST = 16'd50;

    // Per-button result of one sample
    typedef struct packed {
        logic       changed;
        t_btn_state state;
    } t_btn_out;

    // Per-lid result of one sample
    typedef struct packed {
        logic changed;
        logic state;
    } t_lid_out;

    // One full result item
    typedef struct packed {
        t_btn_out a;
        t_btn_out b;
        t_btn_out c;
        t_lid_out lid;
    } t_result;

endpackage

// ===== rtl/bhld_btn.sv =====
// Debounce and long-press tracking for one button pin.
// Depends on bhld_pkg; instantiated three times by the top level.
module bhld_btn (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [bhld_pkg::TIME_W-1:0]   i_now,
    input  logic                          i_level,
    input  logic [bhld_pkg::CFG_W-1:0]    i_hold,
    input  logic [bhld_pkg::CFG_W-1:0]    i_debounce,
    output bhld_pkg::t_btn_out            o_res
);

    bhld_pkg::t_btn_state          r_cand, n_cand;
    bhld_pkg::t_btn_state          r_stable, n_stable;
    logic [bhld_pkg::TIME_W-1:0]   r_stamp, n_stamp;

    bhld_pkg::t_btn_state          w_cur;
    logic [bhld_pkg::TIME_W-1:0]   w_stamp_eff;
    logic [bhld_pkg::TIME_W-1:0]   w_age_old;
    logic [bhld_pkg::TIME_W-1:0]   w_age_eff;
    logic                          w_changed;

    // Candidate from the pin, promoted to held when appropriate
    always_comb begin
        w_age_old = i_now - r_stamp;
        if (i_level) begin
            w_cur = bhld_pkg::BTN_RELEASED;
        end else if (r_stable == bhld_pkg::BTN_HELD) begin
            w_cur = bhld_pkg::BTN_HELD;
        end else if (r_stable == bhld_pkg::BTN_PRESSED &&
                     w_age_old >= {{(bhld_pkg::TIME_W-bhld_pkg::CFG_W){1'b0}}, i_hold}) begin
            w_cur = bhld_pkg::BTN_HELD;
        end else begin
            w_cur = bhld_pkg::BTN_PRESSED;
        end
    end

    // Candidate change restarts the timer, except a move to held
    always_comb begin
        n_cand      = r_cand;
        w_stamp_eff = r_stamp;
        if (w_cur != r_cand) begin
            n_cand = w_cur;
            if (w_cur != bhld_pkg::BTN_HELD) begin
                w_stamp_eff = i_now;
            end
        end
        w_age_eff = i_now - w_stamp_eff;
        w_changed = (w_age_eff >= {{(bhld_pkg::TIME_W-bhld_pkg::CFG_W){1'b0}}, i_debounce})
                    && (w_cur != r_stable);
        n_stamp  = w_changed ? i_now : w_stamp_eff;
        n_stable = w_changed ? w_cur : r_stable;
    end

    assign o_res.changed = w_changed;
    assign o_res.state   = n_stable;

    // State update on each sample transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand   <= bhld_pkg::BTN_RELEASED;
            r_stable <= bhld_pkg::BTN_RELEASED;
            r_stamp  <= '0;
        end else if (i_en) begin
            r_cand   <= n_cand;
            r_stable <= n_stable;
            r_stamp  <= n_stamp;
        end
    end

endmodule

// ===== rtl/bhld_lid.sv =====
// Two-state debounce for the lid pin.
// Depends on bhld_pkg; instantiated once by the top level.
module bhld_lid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [bhld_pkg::TIME_W-1:0]   i_now,
    input  logic                          i_level,
    input  logic [bhld_pkg::CFG_W-1:0]    i_debounce,
    output bhld_pkg::t_lid_out            o_res
);

    logic                          r_cand, n_cand;
    logic                          r_stable, n_stable;
    logic [bhld_pkg::TIME_W-1:0]   r_stamp, n_stamp;

    logic                          w_cur;
    logic [bhld_pkg::TIME_W-1:0]   w_stamp_eff;
    logic [bhld_pkg::TIME_W-1:0]   w_age;
    logic                          w_changed;

    // Active-low pin: low means closed
    always_comb begin
        w_cur       = i_level ? bhld_pkg::LID_OPEN : bhld_pkg::LID_SHUT;
        n_cand      = w_cur;
        w_stamp_eff = (w_cur != r_cand) ? i_now : r_stamp;
        w_age       = i_now - w_stamp_eff;
        w_changed   = (w_age >= {{(bhld_pkg::TIME_W-bhld_pkg::CFG_W){1'b0}}, i_debounce})
                      && (w_cur != r_stable);
        n_stamp     = w_changed ? i_now : w_stamp_eff;
        n_stable    = w_changed ? w_cur : r_stable;
    end

    assign o_res.changed = w_changed;
    assign o_res.state   = n_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand   <= bhld_pkg::LID_OPEN;
            r_stable <= bhld_pkg::LID_OPEN;
            r_stamp  <= '0;
        end else if (i_en) begin
            r_cand   <= n_cand;
            r_stable <= n_stable;
            r_stamp  <= n_stamp;
        end
    end

endmodule

// ===== rtl/button_hold_lid_debouncer_core.sv =====
// Button/lid debouncer with long-press detection.
// Input channel: i_valid / o_stall carry one pin sample (time plus four active-low
// pins); a transfer happens when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry one result per sample: a change flag and
// the stable state of buttons A, B, C and the lid.
// A result is queued at its sample's transfer and offered after earlier results.
// Throughput: one sample per cycle if not stalled. Per-pin state updates in the
// transfer cycle, and results go into a two-entry output queue, so a sample is
// taken while one result still waits. o_stall rises only when two results wait.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 hold time,
// 1 button debounce, 2 lid debounce); index 3 is ignored. Write only when idle.
// Reset (synchronous, active low): all pins released/opened with timestamp zero,
// registers back to 1000/50/50 ms, output queue empty.
// Receiver stall: queued results hold still; once the queue is full, input stalls.
// Depends on bhld_pkg, bhld_btn, bhld_lid and the assertion header.
`include "button_hold_lid_debouncer_core_assert.svh"

module button_hold_lid_debouncer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [bhld_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bhld_pkg::CFG_W-1:0]         i_cfg_data,
    // sample input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [bhld_pkg::TIME_W-1:0]        i_now_ms,
    input  logic                               i_btn_a_level,
    input  logic                               i_btn_b_level,
    input  logic                               i_btn_c_level,
    input  logic                               i_lid_level,
    // result output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_a_changed,
    output logic [1:0]                         o_a_state,
    output logic                               o_b_changed,
    output logic [1:0]                         o_b_state,
    output logic                               o_c_changed,
    output logic [1:0]                         o_c_state,
    output logic                               o_lid_changed,
    output logic                               o_lid_stable
);

    logic [bhld_pkg::CFG_W-1:0] r_hold, r_btn_db, r_lid_db;

    bhld_pkg::t_result r_q [2];
    logic              r_rd;
    logic [1:0]        r_count, n_count;

    logic              w_push, w_pop, w_wr;
    bhld_pkg::t_result w_res, w_head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= bhld_pkg::HOLD_TIME_RST;
            r_btn_db <= bhld_pkg::BTN_DEBOUNCE_RST;
            r_lid_db <= bhld_pkg::LID_DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bhld_pkg::CFG_HOLD_TIME:    r_hold   <= i_cfg_data;
                bhld_pkg::CFG_BTN_DEBOUNCE: r_btn_db <= i_cfg_data;
                bhld_pkg::CFG_LID_DEBOUNCE: r_lid_db <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign o_stall = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    // Per-pin debounce slices
    bhld_btn u_btn_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_push), .i_now(i_now_ms),
        .i_level(i_btn_a_level), .i_hold(r_hold), .i_debounce(r_btn_db), .o_res(w_res.a)
    );
    bhld_btn u_btn_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_push), .i_now(i_now_ms),
        .i_level(i_btn_b_level), .i_hold(r_hold), .i_debounce(r_btn_db), .o_res(w_res.b)
    );
    bhld_btn u_btn_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_push), .i_now(i_now_ms),
        .i_level(i_btn_c_level), .i_hold(r_hold), .i_debounce(r_btn_db), .o_res(w_res.c)
    );
    bhld_lid u_lid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_push), .i_now(i_now_ms),
        .i_level(i_lid_level), .i_debounce(r_lid_db), .o_res(w_res.lid)
    );

    // Two-entry result queue
    assign w_wr = r_rd ^ r_count[0];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[w_wr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    assign w_head        = r_q[r_rd];
    assign o_a_changed   = w_head.a.changed;
    assign o_a_state     = w_head.a.state;
    assign o_b_changed   = w_head.b.changed;
    assign o_b_state     = w_head.b.state;
    assign o_c_changed   = w_head.c.changed;
    assign o_c_state     = w_head.c.state;
    assign o_lid_changed = w_head.lid.changed;
    assign o_lid_stable  = w_head.lid.state;

    // Checks
    `BHLD_ASSERT_NOW(a_count_bound, 1'b1, r_count != 2'd3)
    `BHLD_ASSERT_NEXT(a_push_shows, w_push, o_valid)
    `BHLD_ASSERT_NEXT(a_count_track, w_push && !w_pop, r_count == $past(r_count) + 2'd1)
    `BHLD_ASSERT_NOW(a_stall_full, o_stall, o_valid)

endmodule

// ===== tb/button_hold_lid_debouncer_core_checker.sv =====
`timescale 1ns / 1ps
// Checker for button_hold_lid_debouncer_core: tracks config writes, predicts each sample's
// debounced result and compares the result transfers in order. Depends on bhld_pkg.
module button_hold_lid_debouncer_core_checker
    import bhld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_btn_a_level,
    input  logic                  i_btn_b_level,
    input  logic                  i_btn_c_level,
    input  logic                  i_lid_level,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_a_changed,
    input  logic [1:0]            i_a_state,
    input  logic                  i_b_changed,
    input  logic [1:0]            i_b_state,
    input  logic                  i_c_changed,
    input  logic [1:0]            i_c_state,
    input  logic                  i_lid_changed,
    input  logic                  i_lid_stable,
    output int                    o_mismatch_count,
    output int                    o_pending
);

    // Register copy
    logic [CFG_W-1:0]  hold_ms;
    logic [CFG_W-1:0]  btn_deb_ms;
    logic [CFG_W-1:0]  lid_deb_ms;

    // Per-pin debounce state
    t_btn_state        btn_cand   [3];
    t_btn_state        btn_stable [3];
    logic [TIME_W-1:0] btn_stamp  [3];
    logic              lid_cand;
    logic              lid_stable;
    logic [TIME_W-1:0] lid_stamp;

    t_result           debounced_results [$];
    int                mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [1:0] expv,
                               input logic [1:0] gotv);
        if (gotv !== expv)
            report_mismatch($sformatf("%s expected %0d got %0d", name, expv, gotv));
    endtask

    // Advance the debounce state by one sample and build its result
    task automatic debounce_sample(input logic [TIME_W-1:0] now, input logic [2:0] btn_lvl,
                                   input logic lid_lvl, output t_result res);
        t_btn_state        cur;
        logic [TIME_W-1:0] elapsed;
        logic              changed;
        logic              lid_cur;
        t_btn_out          outs [3];
        int                i;

        for (i = 0; i < 3; i++) begin
            // pin low means pressed; a long enough press is promoted to held
            cur = btn_lvl[i] ? BTN_RELEASED : BTN_PRESSED;
            elapsed = now - btn_stamp[i];
            if (cur == BTN_PRESSED && btn_stable[i] == BTN_HELD)
                cur = BTN_HELD;
            if (cur == BTN_PRESSED && btn_stable[i] == BTN_PRESSED &&
                elapsed >= TIME_W'(hold_ms))
                cur = BTN_HELD;
            // new candidate restarts the timer, except the move to held
            if (cur != btn_cand[i]) begin
                if (cur != BTN_HELD)
                    btn_stamp[i] = now;
                btn_cand[i] = cur;
            end
            elapsed = now - btn_stamp[i];
            changed = (elapsed >= TIME_W'(btn_deb_ms)) && (cur != btn_stable[i]);
            if (changed) begin
                btn_stamp[i]  = now;
                btn_stable[i] = cur;
            end
            outs[i].changed = changed;
            outs[i].state   = btn_stable[i];
        end

        // lid: two states, no hold
        lid_cur = lid_lvl ? LID_OPEN : LID_SHUT;
        if (lid_cur != lid_cand) begin
            lid_stamp = now;
            lid_cand  = lid_cur;
        end
        elapsed = now - lid_stamp;
        changed = (elapsed >= TIME_W'(lid_deb_ms)) && (lid_cur != lid_stable);
        if (changed) begin
            lid_stamp  = now;
            lid_stable = lid_cur;
        end

        res.a           = outs[0];
        res.b           = outs[1];
        res.c           = outs[2];
        res.lid.changed = changed;
        res.lid.state   = lid_stable;
    endtask

    // Everything is sampled at the rising edge, before that edge's updates land
    always @(posedge i_clk) begin : watch
        t_result exp_res;
        int      i;

        if (!i_rst_n) begin
            hold_ms    = HOLD_TIME_RST;
            btn_deb_ms = BTN_DEBOUNCE_RST;
            lid_deb_ms = LID_DEBOUNCE_RST;
            for (i = 0; i < 3; i++) begin
                btn_cand[i]   = BTN_RELEASED;
                btn_stable[i] = BTN_RELEASED;
                btn_stamp[i]  = '0;
            end
            lid_cand   = LID_OPEN;
            lid_stable = LID_OPEN;
            lid_stamp  = '0;
            debounced_results.delete();
        end else begin
            // register writes; the spare index is ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HOLD_TIME:    hold_ms    = i_cfg_data;
                    CFG_BTN_DEBOUNCE: btn_deb_ms = i_cfg_data;
                    CFG_LID_DEBOUNCE: lid_deb_ms = i_cfg_data;
                    default: ;
                endcase
            end

            // result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (debounced_results.size() == 0) begin
                    report_mismatch("result transfer with no sample outstanding");
                end else begin
                    exp_res = debounced_results.pop_front();
                    check_field("a_changed",   exp_res.a.changed,   i_a_changed);
                    check_field("a_state",     exp_res.a.state,     i_a_state);
                    check_field("b_changed",   exp_res.b.changed,   i_b_changed);
                    check_field("b_state",     exp_res.b.state,     i_b_state);
                    check_field("c_changed",   exp_res.c.changed,   i_c_changed);
                    check_field("c_state",     exp_res.c.state,     i_c_state);
                    check_field("lid_changed", exp_res.lid.changed, i_lid_changed);
                    check_field("lid_stable",  exp_res.lid.state,   i_lid_stable);
                end
            end

            // sample transfer
            if (i_in_valid && !i_in_stall) begin
                debounce_sample(i_now_ms, {i_btn_c_level, i_btn_b_level, i_btn_a_level},
                                i_lid_level, exp_res);
                debounced_results.push_back(exp_res);
            end
        end
        o_pending = debounced_results.size();
    end

endmodule

// ===== tb/button_hold_lid_debouncer_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the debouncer testbench: clock, reset, config phases and sample stimulus.
// Depends on bhld_pkg, button_hold_lid_debouncer_core and its checker.
module button_hold_lid_debouncer_core_tb;
    import bhld_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 180;
    localparam int LONG_HOLD_CYCLES = 80;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [TIME_W-1:0]  i_now_ms;
    logic               i_btn_a_level;
    logic               i_btn_b_level;
    logic               i_btn_c_level;
    logic               i_lid_level;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_a_changed;
    logic [1:0]         o_a_state;
    logic               o_b_changed;
    logic [1:0]         o_b_state;
    logic               o_c_changed;
    logic [1:0]         o_c_state;
    logic               o_lid_changed;
    logic               o_lid_stable;

    int                 tx_idle_pct  = 0;
    int                 rx_stall_pct = 0;
    logic               long_hold_req = 1'b0;
    logic               rx_hold_on    = 1'b0;
    int                 mismatch_count;
    int                 pending_count;

    // Time base and intended pin levels for the random samples
    logic [TIME_W-1:0]  sim_ms;
    logic [2:0]         btn_intent;
    logic               lid_intent;
    int                 step_hi;
    int                 hold_hint;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    button_hold_lid_debouncer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_now_ms      (i_now_ms),
        .i_btn_a_level (i_btn_a_level),
        .i_btn_b_level (i_btn_b_level),
        .i_btn_c_level (i_btn_c_level),
        .i_lid_level   (i_lid_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_a_changed   (o_a_changed),
        .o_a_state     (o_a_state),
        .o_b_changed   (o_b_changed),
        .o_b_state     (o_b_state),
        .o_c_changed   (o_c_changed),
        .o_c_state     (o_c_state),
        .o_lid_changed (o_lid_changed),
        .o_lid_stable  (o_lid_stable)
    );

    button_hold_lid_debouncer_core_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_now_ms         (i_now_ms),
        .i_btn_a_level    (i_btn_a_level),
        .i_btn_b_level    (i_btn_b_level),
        .i_btn_c_level    (i_btn_c_level),
        .i_lid_level      (i_lid_level),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_a_changed      (o_a_changed),
        .i_a_state        (o_a_state),
        .i_b_changed      (o_b_changed),
        .i_b_state        (o_b_state),
        .i_c_changed      (o_c_changed),
        .i_c_state        (o_c_state),
        .i_lid_changed    (o_lid_changed),
        .i_lid_stable     (o_lid_stable),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_count)
    );

    // Long receiver hold-off, counted in cycles once requested
    initial begin : long_hold
        wait (long_hold_req);
        @(posedge i_clk);
        rx_hold_on <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        rx_hold_on <= 1'b0;
    end

    // Receiver: the long hold-off takes priority over random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_hold_on) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic set_idle(input t_idle_mode mode);
        tx_idle_pct   = (mode == IDLE_TX) ? 78 : (mode == IDLE_BOTH) ? 36 : 0;
        rx_stall_pct <= (mode == IDLE_RX) ? 78 : (mode == IDLE_BOTH) ? 36 : 0;
    endtask

    // Offer one sample, with random idle cycles first; returns at its transfer edge
    task automatic send_sample(input logic [TIME_W-1:0] now, input logic [2:0] lv,
                               input logic lid);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_now_ms      <= now;
        i_btn_a_level <= lv[0];
        i_btn_b_level <= lv[1];
        i_btn_c_level <= lv[2];
        i_lid_level   <= lid;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register settings, time step scale and idling for each phase
    task automatic apply_phase(input int p);
        logic [CFG_W-1:0] h, bd, ld;
        t_idle_mode       mode;

        case (p)
            0:       begin h = 16'd1000;  bd = 16'd50;    ld = 16'd50;    step_hi = 30;   end
            1:       begin h = 16'd0;     bd = 16'd0;     ld = 16'd0;     step_hi = 3;    end
            2:       begin h = 16'hFFFF;  bd = 16'hFFFF;  ld = 16'hFFFF;  step_hi = 9000; end
            3:       begin h = 16'd200;   bd = 16'd10;    ld = 16'd30;    step_hi = 15;   end
            4:       begin h = 16'd1;     bd = 16'd1;     ld = 16'd0;     step_hi = 2;    end
            5:       begin h = 16'd3000;  bd = 16'd0;     ld = 16'hFFFF;  step_hi = 500;  end
            6:       begin h = 16'd100;   bd = 16'hFFFF;  ld = 16'd5;     step_hi = 40;   end
            7:       begin h = 16'hFFFF;  bd = 16'd0;     ld = 16'd0;     step_hi = 4000; end
            default: begin h = 16'd500;   bd = 16'd20;    ld = 16'd20;    step_hi = 25;   end
        endcase
        hold_hint = h;
        case (p % 4)
            0:       mode = IDLE_NONE;
            1:       mode = IDLE_TX;
            2:       mode = IDLE_RX;
            default: mode = IDLE_BOTH;
        endcase
        write_reg(CFG_HOLD_TIME, h);
        write_reg(CFG_BTN_DEBOUNCE, bd);
        write_reg(CFG_LID_DEBOUNCE, ld);
        // the spare index must not disturb any register
        if (p == NUM_PHASES - 1)
            write_reg(CFG_IDX_SPARE, 16'hFFFF);
        set_idle(mode);
    endtask

    // Mostly coherent presses with bounce, some pure noise
    task automatic send_random_sample();
        int         r;
        int         i;
        logic [2:0] lv;
        logic       lid;

        r = $urandom_range(99);
        if (r < 55)
            sim_ms = sim_ms + $urandom_range(step_hi);
        else if (r < 70)
            sim_ms = sim_ms + $urandom_range(3);
        else if (r < 85)
            sim_ms = sim_ms + $urandom_range(4 * step_hi, step_hi);
        else if (r < 92)
            sim_ms = sim_ms + hold_hint;
        else if (r < 97)
            sim_ms = sim_ms - $urandom_range(step_hi);
        else
            sim_ms = $urandom;

        if ($urandom_range(99) < 10) begin
            lv  = 3'($urandom);
            lid = 1'($urandom);
        end else begin
            for (i = 0; i < 3; i++)
                if ($urandom_range(99) < 5)
                    btn_intent[i] = ~btn_intent[i];
            if ($urandom_range(99) < 5)
                lid_intent = ~lid_intent;
            lv  = btn_intent;
            lid = lid_intent;
            // contact bounce
            if ($urandom_range(99) < 10) begin
                i = $urandom_range(2);
                lv[i] = ~lv[i];
            end
            if ($urandom_range(99) < 8)
                lid = ~lid;
        end
        send_sample(sim_ms, lv, lid);
    endtask

    // Reset settings: press to held, bounce during hold, release, wrap and backward time
    task automatic run_directed();
        send_sample(32'd0,          3'b111, 1'b1);
        send_sample(32'd0,          3'b000, 1'b0);
        send_sample(32'd49,         3'b000, 1'b0);
        send_sample(32'd50,         3'b000, 1'b0);
        send_sample(32'd1049,       3'b000, 1'b0);
        send_sample(32'd1050,       3'b000, 1'b0);
        send_sample(32'd1060,       3'b001, 1'b1);
        send_sample(32'd1070,       3'b000, 1'b0);
        send_sample(32'd1200,       3'b001, 1'b0);
        send_sample(32'd1250,       3'b001, 1'b0);
        send_sample(32'd1250,       3'b011, 1'b0);
        send_sample(32'd1300,       3'b011, 1'b1);
        send_sample(32'd100,        3'b011, 1'b1);
        send_sample(32'hFFFF_FFF0,  3'b110, 1'b1);
        send_sample(32'h0000_0030,  3'b110, 1'b1);
        send_sample(32'h0000_0031,  3'b110, 1'b0);
        send_sample(32'hFFFF_FFFF,  3'b101, 1'b0);
        send_sample(32'hFFFF_FFFF,  3'b101, 1'b0);
        send_sample(32'h7FFF_FFFF,  3'b010, 1'b1);
        send_sample(32'hAAAA_AAAA,  3'b010, 1'b1);
        send_sample(32'h5555_5555,  3'b111, 1'b0);
        send_sample(32'h8000_0000,  3'b000, 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_HOLD_TIME;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_now_ms      = '0;
        i_btn_a_level = 1'b1;
        i_btn_b_level = 1'b1;
        i_btn_c_level = 1'b1;
        i_lid_level   = 1'b1;
        sim_ms        = '0;
        btn_intent    = 3'b111;
        lid_intent    = 1'b1;
        step_hi       = 30;
        hold_hint     = 1000;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            apply_phase(p);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while samples keep coming
                if (p == 0 && n == 40)
                    long_hold_req <= 1'b1;
                // sender pause until the pipe is empty
                if (p == 3 && n == 90)
                    wait_drained();
                send_random_sample();
            end
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bhld_pkg.sv
rtl/bhld_btn.sv
rtl/bhld_lid.sv
rtl/button_hold_lid_debouncer_core.sv
tb/button_hold_lid_debouncer_core_checker.sv
tb/button_hold_lid_debouncer_core_tb.sv
